[rtl/core/mdfs_pkg.sv]
package mdfs_pkg;

  // Default depth of the match store.
  localparam int unsigned MaxMatchesDef = 64;

  // Starting value of the running minimum, above any 16-bit distance.
  localparam logic [16:0] MinStart = 17'd100000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FACTOR   = 2'd0,
    CFG_MIN_KEEP = 2'd1,
    CFG_MAX_KEEP = 2'd2
  } cfg_idx_e;

  // One stored match.
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] query;
    logic [15:0] train;
  } entry_t;

  // One input request.
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] query_index;
    logic [15:0] train_index;
    logic        is_last_match;
  } req_t;

  // One result.
  typedef struct packed {
    logic [15:0] match_distance;
    logic [15:0] match_query;
    logic [15:0] match_train;
    logic [15:0] min_distance;
    logic [15:0] max_distance;
    logic        set_empty;
    logic        is_last_result;
  } res_t;

endpackage

[rtl/core/match_distance_filter_sort.sv]
// Match distance filter and sort. Matches load one per cycle into a store of
// MaxMatches entries while start is high and busy is low; the request flagged
// last closes the set, and busy stays high until the results are out. The
// block then forms the threshold product, counts survivors over the store read
// port and decides. A sorted result then takes one full pass over the store;
// the arrival-order case emits all results during a single pass, and an empty
// set gives a single result marked empty. Each result is on res_o for one
// cycle with done_o high; the receiver cannot stall, so it must take every
// result as it comes.
module match_distance_filter_sort #(
  parameter int unsigned MaxMatches = mdfs_pkg::MaxMatchesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mdfs_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             done_o,
  output mdfs_pkg::res_t   res_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int unsigned IW = $clog2(MaxMatches);
  localparam int unsigned CW = $clog2(MaxMatches + 1);
  localparam int unsigned KW = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    S_LOAD, S_LIM, S_CNT, S_DEC, S_SRT, S_ORD, S_EMP
  } state_e;

  state_e            state_q;
  logic [15:0]       factor_q;
  logic [6:0]        min_keep_q;
  logic [6:0]        max_keep_q;
  logic [CW-1:0]     cnt_q;
  logic [16:0]       min_q;
  logic [15:0]       max_q;
  logic [31:0]       limit_q;
  logic [CW-1:0]     nsurv_q;
  logic [KW-1:0]     kk_q;
  logic [KW-1:0]     emitted_q;
  logic              mode_all_q;
  logic [CW-1:0]     ptr_q;
  logic              rv_q;
  logic [IW-1:0]     ri_q;
  logic [15+IW:0]    last_key_q;
  logic              has_last_q;
  logic [15+IW:0]    best_key_q;
  logic              best_v_q;
  mdfs_pkg::entry_t  best_e_q;
  logic              done_q;
  mdfs_pkg::res_t    res_q;

  logic              accept;
  logic              store_we;
  logic              scanning;
  logic              rd_en;
  logic              scan_done;
  logic              surv;
  logic              cand;
  logic [15+IW:0]    key;
  logic [KW-1:0]     n_ext;
  logic [KW-1:0]     ns_ext;
  logic [KW-1:0]     mink_ext;
  logic [KW-1:0]     maxk_ext;
  logic              last_emit;
  mdfs_pkg::entry_t  wr_e;
  mdfs_pkg::entry_t  rd_e;

  // Handshake and store write.
  assign busy_o   = (state_q != S_LOAD);
  assign accept   = start_i && !busy_o;
  assign store_we = accept && (cnt_q < CW'(MaxMatches));
  assign wr_e     = '{distance: req_i.distance, query: req_i.query_index,
                      train: req_i.train_index};

  // Scan pointer drives the read port during the survey passes.
  assign scanning  = (state_q == S_CNT) || (state_q == S_SRT) || (state_q == S_ORD);
  assign rd_en     = scanning && (ptr_q < cnt_q);
  assign scan_done = (ptr_q == cnt_q) && !rv_q;

  mdfs_store #(.Depth(MaxMatches)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (wr_e),
    .raddr_i (ptr_q[IW-1:0]),
    .rdata_o (rd_e)
  );

  // Survivor test and sort key of the entry now on the read port.
  assign surv = {8'd0, rd_e.distance, 8'd0} < limit_q;
  assign key  = {rd_e.distance, ri_q};
  assign cand = (mode_all_q || surv) && (!has_last_q || (key > last_key_q));

  assign n_ext     = KW'(cnt_q);
  assign ns_ext    = KW'(nsurv_q);
  assign mink_ext  = KW'(min_keep_q);
  assign maxk_ext  = KW'(max_keep_q);
  assign last_emit = (emitted_q + KW'(1)) == kk_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q   <= 16'd512;
      min_keep_q <= 7'd8;
      max_keep_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mdfs_pkg::CFG_FACTOR:   factor_q   <= cfg_data_i;
        mdfs_pkg::CFG_MIN_KEEP: min_keep_q <= cfg_data_i[6:0];
        mdfs_pkg::CFG_MAX_KEEP: max_keep_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Control sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      min_q      <= mdfs_pkg::MinStart;
      max_q      <= '0;
      limit_q    <= '0;
      nsurv_q    <= '0;
      kk_q       <= '0;
      emitted_q  <= '0;
      mode_all_q <= 1'b0;
      ptr_q      <= '0;
      rv_q       <= 1'b0;
      ri_q       <= '0;
      last_key_q <= '0;
      has_last_q <= 1'b0;
      best_key_q <= '0;
      best_v_q   <= 1'b0;
      best_e_q   <= '0;
      done_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      done_q <= 1'b0;
      // Read pipeline shared by all passes.
      rv_q <= rd_en;
      if (rd_en) begin
        ptr_q <= ptr_q + CW'(1);
        ri_q  <= ptr_q[IW-1:0];
      end
      case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (store_we) begin
              cnt_q <= cnt_q + CW'(1);
              if ({1'b0, req_i.distance} < min_q) min_q <= {1'b0, req_i.distance};
              if (req_i.distance > max_q) max_q <= req_i.distance;
            end
            if (req_i.is_last_match) state_q <= S_LIM;
          end
        end
        S_LIM: begin
          limit_q <= factor_q * min_q[15:0];
          ptr_q   <= '0;
          nsurv_q <= '0;
          state_q <= S_CNT;
        end
        S_CNT: begin
          if (rv_q && surv) nsurv_q <= nsurv_q + CW'(1);
          if (scan_done) state_q <= S_DEC;
        end
        S_DEC: begin
          emitted_q  <= '0;
          has_last_q <= 1'b0;
          best_v_q   <= 1'b0;
          ptr_q      <= '0;
          if (ns_ext < mink_ext) begin
            mode_all_q <= 1'b1;
            kk_q       <= (n_ext < mink_ext) ? n_ext : mink_ext;
            state_q    <= ((n_ext == '0) || (mink_ext == '0)) ? S_EMP : S_SRT;
          end else if (ns_ext > maxk_ext) begin
            kk_q    <= maxk_ext;
            state_q <= (maxk_ext == '0) ? S_EMP : S_ORD;
          end else begin
            mode_all_q <= 1'b0;
            kk_q       <= ns_ext;
            state_q    <= (ns_ext == '0) ? S_EMP : S_SRT;
          end
        end
        S_SRT: begin
          // Track the smallest key above the one emitted last.
          if (rv_q && cand && (!best_v_q || (key < best_key_q))) begin
            best_v_q   <= 1'b1;
            best_key_q <= key;
            best_e_q   <= rd_e;
          end
          if (scan_done) begin
            done_q     <= 1'b1;
            res_q      <= '{best_e_q.distance, best_e_q.query, best_e_q.train,
                            min_q[15:0], max_q, 1'b0, last_emit};
            last_key_q <= best_key_q;
            has_last_q <= 1'b1;
            emitted_q  <= emitted_q + KW'(1);
            best_v_q   <= 1'b0;
            ptr_q      <= '0;
            if (last_emit) begin
              cnt_q   <= '0;
              min_q   <= mdfs_pkg::MinStart;
              max_q   <= '0;
              state_q <= S_LOAD;
            end
          end
        end
        S_ORD: begin
          // Survivors go out in arrival order until the limit is reached.
          if (rv_q && surv && (emitted_q < kk_q)) begin
            done_q    <= 1'b1;
            res_q     <= '{rd_e.distance, rd_e.query, rd_e.train,
                           min_q[15:0], max_q, 1'b0, last_emit};
            emitted_q <= emitted_q + KW'(1);
          end
          if (scan_done) begin
            cnt_q   <= '0;
            min_q   <= mdfs_pkg::MinStart;
            max_q   <= '0;
            state_q <= S_LOAD;
          end
        end
        S_EMP: begin
          done_q  <= 1'b1;
          res_q   <= '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
          cnt_q   <= '0;
          min_q   <= mdfs_pkg::MinStart;
          max_q   <= '0;
          state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // An empty result always closes its set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.set_empty |-> res_o.is_last_result)
    else $error("empty result without last mark");

  // A retained match never lies below the set minimum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.set_empty |-> res_o.match_distance >= res_o.min_distance)
    else $error("retained distance below minimum");

  // The fill count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxMatches))
    else $error("fill count overflow");

  // No more results are emitted than the keep count allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRT || state_q == S_ORD) |-> emitted_q <= kk_q)
    else $error("too many results emitted");

endmodule

[rtl/core/mdfs_store.sv]
module mdfs_store #(
  parameter int unsigned Depth = mdfs_pkg::MaxMatchesDef,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  mdfs_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output mdfs_pkg::entry_t  rdata_o
);

  mdfs_pkg::entry_t mem_q [Depth];

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[dv/match_filter_checker.sv]
module match_filter_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_o,
  input  mdfs_pkg::req_t req_i,
  input  logic           done_o,
  input  mdfs_pkg::res_t res_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = mdfs_pkg::MaxMatchesDef;

  mdfs_pkg::entry_t set_store [Depth];
  int unsigned      set_count  = 0;
  logic [16:0]      low_dist   = mdfs_pkg::MinStart;
  logic [15:0]      high_dist  = '0;
  logic [15:0]      factor_q   = 16'd512;
  logic [6:0]       min_keep_q = 7'd8;
  logic [6:0]       max_keep_q = 7'd64;
  int               fails      = 0;
  int               pending_n  = 0;
  mdfs_pkg::res_t   expected_matches [$];

  assign fail_count_o = fails;
  assign pending_o    = pending_n;

  // Print one mismatch line and count it.
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Append one expected result.
  task automatic queue_result(mdfs_pkg::res_t res);
    expected_matches = {expected_matches, res};
  endtask

  // Ascending stable insertion sort of store indexes by distance.
  task automatic sort_indexes(ref int unsigned idx [Depth], input int unsigned n);
    int unsigned v;
    int          j;
    for (int i = 1; i < n; i++) begin
      v = idx[i];
      j = i;
      while (j > 0 && set_store[idx[j-1]].distance > set_store[v].distance) begin
        idx[j] = idx[j-1];
        j--;
      end
      idx[j] = v;
    end
  endtask

  // Close the set: filter, select and queue the kept matches.
  task automatic close_set();
    int unsigned    idx [Depth];
    bit             keep [Depth];
    int unsigned    n_surv, k;
    logic [15:0]    mn;
    logic [31:0]    limit;
    mdfs_pkg::res_t r;
    mn = low_dist[15:0];
    limit = factor_q * mn;
    n_surv = 0;
    k = 0;
    for (int i = 0; i < set_count; i++) begin
      keep[i] = ({16'd0, set_store[i].distance} << 8) < limit;
      n_surv += keep[i];
    end
    if (n_surv < min_keep_q) begin
      for (int i = 0; i < set_count; i++) idx[i] = i;
      sort_indexes(idx, set_count);
      k = (set_count < min_keep_q) ? set_count : min_keep_q;
    end else if (n_surv > max_keep_q) begin
      for (int i = 0; i < set_count && k < max_keep_q; i++)
        if (keep[i]) idx[k++] = i;
    end else begin
      for (int i = 0; i < set_count; i++)
        if (keep[i]) idx[k++] = i;
      sort_indexes(idx, k);
    end
    if (k == 0) begin
      r = '0;
      r.set_empty = 1'b1;
      r.is_last_result = 1'b1;
      queue_result(r);
    end
    for (int i = 0; i < k; i++) begin
      r.match_distance = set_store[idx[i]].distance;
      r.match_query    = set_store[idx[i]].query;
      r.match_train    = set_store[idx[i]].train;
      r.min_distance   = mn;
      r.max_distance   = high_dist;
      r.set_empty      = 1'b0;
      r.is_last_result = (i + 1 == k);
      queue_result(r);
    end
    set_count = 0;
    low_dist  = mdfs_pkg::MinStart;
    high_dist = '0;
  endtask

  // Track register writes, accepted requests and strobed results.
  always @(posedge clk_i) begin
    mdfs_pkg::res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mdfs_pkg::CFG_FACTOR:   factor_q   = cfg_data_i;
          mdfs_pkg::CFG_MIN_KEEP: min_keep_q = cfg_data_i[6:0];
          mdfs_pkg::CFG_MAX_KEEP: max_keep_q = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (done_o) begin
        if (expected_matches.size() == 0) begin
          $display("unexpected result %0h at %0t", res_o, $realtime);
          fails++;
        end else begin
          want = expected_matches.pop_front();
          if (res_o.match_distance !== want.match_distance)
            report_mismatch("match_distance", res_o.match_distance, want.match_distance);
          if (res_o.match_query !== want.match_query)
            report_mismatch("match_query", res_o.match_query, want.match_query);
          if (res_o.match_train !== want.match_train)
            report_mismatch("match_train", res_o.match_train, want.match_train);
          if (res_o.min_distance !== want.min_distance)
            report_mismatch("min_distance", res_o.min_distance, want.min_distance);
          if (res_o.max_distance !== want.max_distance)
            report_mismatch("max_distance", res_o.max_distance, want.max_distance);
          if (res_o.set_empty !== want.set_empty)
            report_mismatch("set_empty", 16'(res_o.set_empty), 16'(want.set_empty));
          if (res_o.is_last_result !== want.is_last_result)
            report_mismatch("is_last_result", 16'(res_o.is_last_result),
                            16'(want.is_last_result));
        end
      end
      if (start_i && !busy_o) begin
        if (set_count < Depth) begin
          set_store[set_count] = '{req_i.distance, req_i.query_index, req_i.train_index};
          if (req_i.distance < low_dist) low_dist = {1'b0, req_i.distance};
          if (req_i.distance > high_dist) high_dist = req_i.distance;
          set_count++;
        end
        if (req_i.is_last_match) close_set();
      end
      pending_n = expected_matches.size();
    end
  end
endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  mdfs_pkg::req_t req_i;
  logic           busy_o;
  logic           done_o;
  mdfs_pkg::res_t res_o;
  logic           cfg_we_i;
  logic [1:0]     cfg_idx_i;
  logic [15:0]    cfg_data_i;
  int             fail_count;
  int             pending;

  match_distance_filter_sort dut (.*);

  match_filter_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Distance pools: a narrow pool makes ties and many survivors.
  function automatic logic [15:0] pick_distance(int unsigned style);
    case (style)
      0: return 16'($urandom_range(0, 7));
      1: return 16'($urandom_range(100, 400));
      2: return 16'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  // Present one request and wait until it is accepted; start stays high.
  task automatic send_request(logic [15:0] d, logic [15:0] q, logic [15:0] t, logic last);
    start_i <= 1'b1;
    req_i   <= '{d, q, t, last};
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and idle for a number of cycles.
  task automatic pause(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Send one set of matches with random content and optional gaps.
  task automatic send_set(int unsigned n, int unsigned style, bit gaps);
    for (int i = 0; i < n; i++) begin
      send_request(pick_distance(style), 16'($urandom), 16'($urandom), i == n - 1);
      if (gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
    end
  endtask

  // Let all results drain, then a quiet margin.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(mdfs_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = mdfs_pkg::CFG_FACTOR;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single match, extremes, ties, and a store overflow.
    send_request(16'hffff, 16'hffff, 16'hffff, 1'b1);
    send_request(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_request(16'd5, 16'd1, 16'd1, 1'b0);
    send_request(16'd5, 16'd2, 16'd2, 1'b0);
    send_request(16'd3, 16'd3, 16'd3, 1'b0);
    send_request(16'd5, 16'd4, 16'd4, 1'b1);
    drain();
    write_reg(mdfs_pkg::CFG_MIN_KEEP, 16'd0);
    write_reg(mdfs_pkg::CFG_FACTOR, 16'd0);
    send_request(16'd9, 16'haaaa, 16'h5555, 1'b1);
    drain();
    write_reg(mdfs_pkg::CFG_FACTOR, 16'hffff);
    write_reg(mdfs_pkg::CFG_MIN_KEEP, 16'd5);
    write_reg(mdfs_pkg::CFG_MAX_KEEP, 16'd2);
    send_set(4, 1, 1'b0);
    drain();
    write_reg(mdfs_pkg::CFG_MIN_KEEP, 16'd64);
    write_reg(mdfs_pkg::CFG_MAX_KEEP, 16'd0);
    send_set(66, 2, 1'b0);
    drain();
    sent = 77;

    // Random sets under changing settings.
    while (sent < 470) begin
      case ($urandom_range(0, 3))
        0: write_reg(mdfs_pkg::CFG_FACTOR, 16'($urandom));
        1: write_reg(mdfs_pkg::CFG_FACTOR, 16'($urandom_range(256, 1024)));
        2: write_reg(mdfs_pkg::CFG_FACTOR,
                     ($urandom_range(0, 1) != 0) ? 16'hffff : 16'd0);
        default: ;
      endcase
      write_reg(mdfs_pkg::CFG_MIN_KEEP, 16'($urandom_range(0, 64)));
      write_reg(mdfs_pkg::CFG_MAX_KEEP,
                ($urandom_range(0, 3) == 0) ? 16'd64 : 16'($urandom_range(0, 20)));
      for (int s = 0; s < 3; s++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 12);
        send_set(n, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
        sent += n;
        if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 30));
      end
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end
endmodule

[sim.f]
rtl/core/mdfs_pkg.sv
rtl/core/mdfs_store.sv
rtl/core/match_distance_filter_sort.sv
dv/match_filter_checker.sv
dv/tb_top.sv
